@@ rtl/ccdp_pkg.sv @@
package ccdp_pkg;

    localparam int MAX_AGE_BITS_DEF = 32;
    localparam int SECONDS_W        = 32;
    localparam int QUEUE_DEPTH      = 4;

    // candidate bit positions in the match mask
    localparam int CAND_STORE = 0;
    localparam int CAND_CACHE = 1;
    localparam int CAND_AGE   = 2;
    localparam logic [2:0] CAND_ALL = 3'b111;

    // first character sits in the top byte
    localparam logic [63:0] PAT_STORE = "no-store";
    localparam logic [63:0] PAT_CACHE = "no-cache";
    localparam logic [63:0] PAT_AGE   = "max-age=";

    typedef struct packed {
        logic [7:0] header_byte;
        logic       end_of_header;
        logic       empty_header;
    } t_in_beat;

    typedef struct packed {
        logic               no_store_seen;
        logic               no_cache_seen;
        logic               max_age_present;
        logic signed [31:0] max_age_seconds;
    } t_out_beat;

    typedef enum logic [2:0] {
        CL_COMMA,
        CL_BLANK,   // space or tab
        CL_SPACE,   // LF, VT, FF, CR
        CL_SIGN,
        CL_DIGIT,
        CL_OTHER
    } t_char_class;

    // classified beat handed from front to back
    typedef struct packed {
        logic [7:0]  ch;
        t_char_class cls;
        logic        last;
        logic        absent;
    } t_beat;

    function automatic logic [7:0] pat_byte(input logic [63:0] pat, input logic [2:0] pos);
        return pat[{~pos, 3'b000} +: 8];
    endfunction

endpackage

@@ rtl/ccdp_stream_if.sv @@
interface ccdp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/cache_control_directive_parser_top.sv @@
// Cache-Control header parser.
// i_in takes one header byte per beat with end_of_header on the final byte;
// a beat with empty_header set stands for an absent header and yields an
// all-zero result on its own. o_out gives one beat per header: the no-store,
// no-cache and max-age flags and the signed max-age value in seconds.
// Throughput is one byte per cycle while o_out keeps up: the front classifies
// each byte in the accepting cycle and writes a 4-entry queue; the back parser
// retires one queued byte per cycle. From the final byte to the result, the
// path runs through the queue write, then the parser's result register.
// When o_out stalls, the back holds a header's final byte in the queue while
// the result register is full; ordinary bytes keep draining, and the queue
// absorbs up to three more beats behind the held byte before i_in.ready drops.
// Reset (synchronous, active low) empties the queue, drops any pending
// result and returns the parser to the start of a header.
module cache_control_directive_parser_top #(
    parameter int MAX_AGE_BITS = ccdp_pkg::MAX_AGE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ccdp_stream_if.sink   i_in,
    ccdp_stream_if.source o_out
);
    import ccdp_pkg::*;

    ccdp_stream_if #(.T(t_beat)) w_front_q ();
    ccdp_stream_if #(.T(t_beat)) w_q_back ();

    ccdp_front u_front (
        .i_in (i_in),
        .o_q  (w_front_q)
    );

    ccdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_q),
        .o_pop   (w_q_back)
    );

    ccdp_back #(
        .MAX_AGE_BITS (MAX_AGE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (w_q_back),
        .o_out   (o_out)
    );

endmodule

@@ rtl/ccdp_front.sv @@
module ccdp_front (
    ccdp_stream_if.sink   i_in,
    ccdp_stream_if.source o_q
);
    import ccdp_pkg::*;

    t_in_beat    w_in;
    logic [7:0]  w_ch;
    t_char_class w_cls;

    assign w_in = i_in.data;

    // fold A-Z to lower case
    assign w_ch = (w_in.header_byte >= "A" && w_in.header_byte <= "Z") ?
                  w_in.header_byte + 8'd32 : w_in.header_byte;

    always_comb begin
        if (w_ch == ",") begin
            w_cls = CL_COMMA;
        end else if (w_ch == " " || w_ch == 8'h09) begin
            w_cls = CL_BLANK;
        end else if (w_ch >= 8'h0a && w_ch <= 8'h0d) begin
            w_cls = CL_SPACE;
        end else if (w_ch == "+" || w_ch == "-") begin
            w_cls = CL_SIGN;
        end else if (w_ch >= "0" && w_ch <= "9") begin
            w_cls = CL_DIGIT;
        end else begin
            w_cls = CL_OTHER;
        end
    end

    assign o_q.valid       = i_in.valid;
    assign o_q.data.ch     = w_ch;
    assign o_q.data.cls    = w_cls;
    assign o_q.data.last   = w_in.end_of_header;
    assign o_q.data.absent = w_in.empty_header;
    assign i_in.ready      = o_q.ready;

endmodule

@@ rtl/ccdp_queue.sv @@
module ccdp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ccdp_stream_if.sink   i_push,
    ccdp_stream_if.source o_pop
);
    import ccdp_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

    t_beat         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_push, w_pop;

    assign i_push.ready = (r_cnt != FULL_CNT);
    assign o_pop.valid  = (r_cnt != '0);
    assign o_pop.data   = r_mem[r_rptr];

    assign w_push = i_push.valid && i_push.ready;
    assign w_pop  = o_pop.valid && o_pop.ready;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_push) begin
            n_wptr = (r_wptr == LAST_SLOT) ? '0 : r_wptr + PW'(1);
        end
        if (w_pop) begin
            n_rptr = (r_rptr == LAST_SLOT) ? '0 : r_rptr + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push.data;
        end
    end

endmodule

@@ rtl/ccdp_back.sv @@
module ccdp_back #(
    parameter int MAX_AGE_BITS = ccdp_pkg::MAX_AGE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ccdp_stream_if.sink   i_q,
    ccdp_stream_if.source o_out
);
    import ccdp_pkg::*;

    localparam int AW = MAX_AGE_BITS;
    localparam int PW = AW + 4;
    localparam int XW = (AW > SECONDS_W) ? AW : SECONDS_W;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_MATCH,
        PH_TAIL,
        PH_NUM_WS,
        PH_NUM_SIGN,
        PH_NUM_DIG,
        PH_NUM_DONE,
        PH_DEAD
    } t_phase;

    t_phase          r_phase;
    logic [2:0]      r_pos;
    logic [2:0]      r_mask;
    logic [AW-1:0]   r_acc;
    logic            r_neg, r_dig, r_ovf;
    logic            r_store, r_cache, r_age;
    logic [31:0]     r_value;
    logic            r_out_valid;
    t_out_beat       r_out;

    t_beat           w_b;
    logic [2:0]      w_mmask;
    logic [PW-1:0]   w_prod, w_lim;
    logic            w_comma, w_fire, w_fin, w_pop;

    t_phase          n_phase;
    logic [2:0]      n_pos, n_mask;
    logic [AW-1:0]   n_acc;
    logic            n_neg, n_dig, n_ovf, n_age;

    t_phase          w_sphase;
    logic [2:0]      w_smask;
    logic [AW-1:0]   w_sacc;
    logic            w_sneg, w_sdig, w_sovf;
    logic [XW-1:0]   w_accx;
    logic            w_fstore, w_fcache;
    logic [31:0]     w_fvalue;

    logic            w_do_match, w_do_digit;

    assign w_b     = i_q.data;
    assign w_comma = (w_b.cls == CL_COMMA);
    assign w_fire  = w_b.absent || w_b.last;

    assign w_mmask[CAND_STORE] = r_mask[CAND_STORE] && (pat_byte(PAT_STORE, r_pos) == w_b.ch);
    assign w_mmask[CAND_CACHE] = r_mask[CAND_CACHE] && (pat_byte(PAT_CACHE, r_pos) == w_b.ch);
    assign w_mmask[CAND_AGE]   = r_mask[CAND_AGE]   && (pat_byte(PAT_AGE, r_pos) == w_b.ch);

    // acc * 10 + digit against the signed magnitude limit
    assign w_prod = (PW'(r_acc) << 3) + (PW'(r_acc) << 1) + PW'(w_b.ch[3:0]);
    assign w_lim  = r_neg ? (PW'(1) << (AW - 1)) : ((PW'(1) << (AW - 1)) - PW'(1));

    // per-byte token step
    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_mask     = r_mask;
        n_acc      = r_acc;
        n_neg      = r_neg;
        n_dig      = r_dig;
        n_ovf      = r_ovf;
        n_age      = r_age;
        w_do_match = 1'b0;
        w_do_digit = 1'b0;

        unique case (r_phase)
            PH_LEAD:  w_do_match = (w_b.cls != CL_BLANK);
            PH_MATCH: w_do_match = 1'b1;
            PH_TAIL: begin
                if (w_b.cls != CL_BLANK) n_phase = PH_DEAD;
            end
            PH_NUM_WS: begin
                if (w_b.cls inside {CL_BLANK, CL_SPACE}) begin
                    n_phase = PH_NUM_WS;
                end else if (w_b.cls == CL_SIGN) begin
                    n_neg   = (w_b.ch == "-");
                    n_phase = PH_NUM_SIGN;
                end else if (w_b.cls == CL_DIGIT) begin
                    w_do_digit = 1'b1;
                end else begin
                    n_phase = PH_NUM_DONE;
                end
            end
            PH_NUM_SIGN, PH_NUM_DIG: begin
                if (w_b.cls == CL_DIGIT) w_do_digit = 1'b1;
                else n_phase = PH_NUM_DONE;
            end
            default: ;
        endcase

        if (w_do_match) begin
            n_mask = w_mmask;
            n_pos  = r_pos + 3'd1;
            if (w_mmask == 3'b000) begin
                n_phase = PH_DEAD;
            end else if (r_pos == 3'd7) begin
                if (w_mmask[CAND_AGE]) begin
                    n_age   = 1'b1;
                    n_phase = PH_NUM_WS;
                end else begin
                    n_phase = PH_TAIL;
                end
            end else begin
                n_phase = PH_MATCH;
            end
        end

        if (w_do_digit) begin
            n_phase = PH_NUM_DIG;
            n_dig   = 1'b1;
            if (!r_ovf) begin
                if (w_prod > w_lim) n_ovf = 1'b1;
                else n_acc = w_prod[AW-1:0];
            end
        end
    end

    // token close: a comma closes the token as it stood, end of header the stepped one
    always_comb begin
        w_sphase = w_comma ? r_phase : n_phase;
        w_smask  = w_comma ? r_mask  : n_mask;
        w_sacc   = w_comma ? r_acc   : n_acc;
        w_sneg   = w_comma ? r_neg   : n_neg;
        w_sdig   = w_comma ? r_dig   : n_dig;
        w_sovf   = w_comma ? r_ovf   : n_ovf;
        w_accx   = XW'(w_sacc);

        w_fstore = r_store || (w_sphase == PH_TAIL && w_smask[CAND_STORE]);
        w_fcache = r_cache || (w_sphase == PH_TAIL && w_smask[CAND_CACHE]);
        w_fvalue = r_value;
        if (w_sphase == PH_NUM_WS || w_sphase == PH_NUM_SIGN ||
            w_sphase == PH_NUM_DIG || w_sphase == PH_NUM_DONE) begin
            if (!w_sdig || w_sovf) w_fvalue = '0;
            else if (w_sneg) w_fvalue = 32'd0 - w_accx[31:0];
            else w_fvalue = w_accx[31:0];
        end
    end

    assign w_fin = w_comma || w_b.last;

    assign i_q.ready   = !w_fire || !r_out_valid || o_out.ready;
    assign w_pop       = i_q.valid && i_q.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_pos       <= '0;
            r_mask      <= CAND_ALL;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_dig       <= 1'b0;
            r_ovf       <= 1'b0;
            r_store     <= 1'b0;
            r_cache     <= 1'b0;
            r_age       <= 1'b0;
            r_value     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && !(w_pop && w_fire)) r_out_valid <= 1'b0;
            if (w_pop) begin
                if (w_fin || w_b.absent) begin
                    r_phase <= PH_LEAD;
                    r_pos   <= '0;
                    r_mask  <= CAND_ALL;
                    r_acc   <= '0;
                    r_neg   <= 1'b0;
                    r_dig   <= 1'b0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_pos   <= n_pos;
                    r_mask  <= n_mask;
                    r_acc   <= n_acc;
                    r_neg   <= n_neg;
                    r_dig   <= n_dig;
                    r_ovf   <= n_ovf;
                end

                if (w_fire) begin
                    r_store     <= 1'b0;
                    r_cache     <= 1'b0;
                    r_age       <= 1'b0;
                    r_value     <= '0;
                    r_out_valid <= 1'b1;
                    if (w_b.absent) begin
                        r_out <= '0;
                    end else begin
                        r_out.no_store_seen   <= w_fstore;
                        r_out.no_cache_seen   <= w_fcache;
                        r_out.max_age_present <= n_age;
                        r_out.max_age_seconds <= n_age ? w_fvalue : '0;
                    end
                end else begin
                    r_age <= n_age;
                    if (w_fin) begin
                        r_store <= w_fstore;
                        r_cache <= w_fcache;
                        r_value <= w_fvalue;
                    end
                end
            end
        end
    end

endmodule
